### hdl/mi3_pkg.sv
package mi3_pkg;

    localparam int FRAC_BITS = 16;
    localparam int ELEM_W    = 32;
    localparam int N_ELEM    = 9;
    localparam int DATA_W    = ELEM_W * N_ELEM;
    localparam int PROD_W    = 2 * ELEM_W;
    localparam int COF_W     = PROD_W + 1;
    localparam int PART_W    = ELEM_W + (COF_W - ELEM_W) + 1;
    localparam int TERM_W    = ELEM_W + COF_W + 1;
    localparam int DET_W     = TERM_W + 2;
    localparam int DABS_W    = DET_W - 1;
    localparam int THR_W     = 31;
    localparam logic [THR_W-1:0] THR_RESET = THR_W'(1);
    localparam int QBITS     = ELEM_W + 1;
    localparam int DIV_ST    = QBITS + 2;
    localparam int TOP_ST    = 6;

    // cofactor k = e[a]*e[b] - e[c]*e[d], elements in column-major order
    localparam int COF_SEL [N_ELEM][4] = '{
        '{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
        '{6, 5, 3, 8}, '{0, 8, 6, 2}, '{3, 2, 0, 5},
        '{3, 7, 6, 4}, '{6, 1, 0, 7}, '{0, 4, 3, 1}
    };

    // determinant expansion: element index paired with cofactor 0..2
    localparam int DET_SEL [3] = '{0, 3, 6};

    typedef logic signed [ELEM_W-1:0] elem_t;
    typedef logic signed [COF_W-1:0]  cof_t;

endpackage

### hdl/mi3_div.sv
module mi3_div #(
    parameter int FRAC_BITS = mi3_pkg::FRAC_BITS
) (
    input  logic                                clk,
    input  logic [mi3_pkg::DIV_ST-1:0]          ld,
    input  mi3_pkg::cof_t                       cof,
    input  logic [mi3_pkg::DABS_W-1:0]          dabs,
    input  logic                                dneg,
    input  logic                                zero,
    output logic signed [mi3_pkg::ELEM_W-1:0]   q,
    output logic                                zero_q
);

    localparam int EW  = mi3_pkg::ELEM_W;
    localparam int QB  = mi3_pkg::QBITS;
    localparam int DW  = mi3_pkg::DABS_W;
    localparam int MW  = mi3_pkg::COF_W - 1;
    localparam int NW  = MW + 2 * FRAC_BITS;
    localparam int RW  = ((NW > DW + QB) ? NW : DW + QB) + 1;
    localparam logic [EW-1:0] MAX_POS = {1'b0, {(EW-1){1'b1}}};
    localparam logic [EW-1:0] MIN_NEG = {1'b1, {(EW-1){1'b0}}};

    logic [RW-1:0] r_reg    [0:QB];
    logic [QB-1:0] q_reg    [0:QB];
    logic [DW-1:0] d_reg    [0:QB];
    logic          neg_reg  [0:QB];
    logic          sat_reg  [0:QB];
    logic          zero_reg [0:QB];

    logic [MW-1:0] cmag;
    logic [RW-1:0] n_sh;
    logic [RW-1:0] d_sh;

    assign cmag = cof[mi3_pkg::COF_W-1] ? MW'(-cof) : MW'(cof);
    assign n_sh = RW'(cmag) << (2 * FRAC_BITS);
    assign d_sh = RW'(dabs) << QB;

    always_ff @(posedge clk)
    begin
        if (ld[0])
        begin
            r_reg[0]    <= n_sh;
            q_reg[0]    <= '0;
            d_reg[0]    <= dabs;
            neg_reg[0]  <= cof[mi3_pkg::COF_W-1] ^ dneg;
            sat_reg[0]  <= (n_sh >= d_sh);
            zero_reg[0] <= zero;
        end
    end

    // one quotient bit per stage, msb first
    for (genvar j = 1; j <= QB; j++)
    begin : g_step
        logic [RW-1:0] ds;
        logic          take;

        assign ds   = RW'(d_reg[j-1]) << (QB - j);
        assign take = (r_reg[j-1] >= ds);

        always_ff @(posedge clk)
        begin
            if (ld[j])
            begin
                r_reg[j]        <= take ? (r_reg[j-1] - ds) : r_reg[j-1];
                q_reg[j]        <= q_reg[j-1] | (QB'(take) << (QB - j));
                d_reg[j]        <= d_reg[j-1];
                neg_reg[j]      <= neg_reg[j-1];
                sat_reg[j]      <= sat_reg[j-1];
                zero_reg[j]     <= zero_reg[j-1];
            end
        end
    end

    logic          rnd_up;
    logic [QB:0]   mag;
    logic [EW-1:0] res_next;
    logic [EW-1:0] res_reg;
    logic          zq_reg;

    assign rnd_up = ({r_reg[QB], 1'b0} >= (RW + 1)'(d_reg[QB]));
    assign mag    = {1'b0, q_reg[QB]} + (QB + 1)'(rnd_up);

    always_comb
    begin
        if (zero_reg[QB])
            res_next = '0;
        else if (neg_reg[QB])
            res_next = (sat_reg[QB] || mag > (QB + 1)'(MIN_NEG)) ? MIN_NEG
                                                                  : EW'(-mag);
        else
            res_next = (sat_reg[QB] || mag > (QB + 1)'(MAX_POS)) ? MAX_POS
                                                                  : EW'(mag);
    end

    always_ff @(posedge clk)
    begin
        if (ld[QB+1])
        begin
            res_reg <= res_next;
            zq_reg  <= zero_reg[QB];
        end
    end

    assign q      = res_reg;
    assign zero_q = zq_reg;

endmodule

### hdl/matrix_inverse_3x3.sv
// Throughput: one matrix per cycle when the output is not stalled;
// 6 product/cofactor/determinant stages feed a 35-stage restoring
// divider, one quotient bit per stage.
// Stages hold their beat under back-pressure and bubbles are squeezed out.
// Reset (rst_n, async, active low) clears all valid bits and sets
// singular_threshold to 1.
module matrix_inverse_3x3 #(
    parameter int FRAC_BITS = mi3_pkg::FRAC_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [mi3_pkg::THR_W-1:0]         cfg_wdata,  // singular_threshold
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // m_r0_c0, m_r1_c0, m_r2_c0, m_r0_c1, m_r1_c1, m_r2_c1, m_r0_c2, m_r1_c2,
    // m_r2_c2; 32 bits each
    input  logic [mi3_pkg::DATA_W-1:0]        s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // inv_r0_c0, inv_r1_c0, inv_r2_c0, inv_r0_c1, inv_r1_c1, inv_r2_c1,
    // inv_r0_c2, inv_r1_c2, inv_r2_c2; 32 bits each
    output logic [mi3_pkg::DATA_W-1:0]        m_tdata,
    output logic                              m_tuser     // singular
);

    localparam int EW = mi3_pkg::ELEM_W;
    localparam int NE = mi3_pkg::N_ELEM;
    localparam int PW = mi3_pkg::PROD_W;
    localparam int CW = mi3_pkg::COF_W;
    localparam int AW = mi3_pkg::PART_W;
    localparam int TW = mi3_pkg::TERM_W;
    localparam int DT = mi3_pkg::DET_W;
    localparam int DA = mi3_pkg::DABS_W;
    localparam int TS = mi3_pkg::TOP_ST;
    localparam int NS = TS + mi3_pkg::DIV_ST;

    logic [mi3_pkg::THR_W-1:0] thr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thr_reg <= mi3_pkg::THR_RESET;
        else if (cfg_we)
            thr_reg <= cfg_wdata;
    end

    // pipeline control
    logic [NS-1:0] v_reg;
    logic [NS:0]   ld;

    assign ld[NS] = m_tready;
    for (genvar k = 0; k < NS; k++)
    begin : g_ld
        assign ld[k] = ~v_reg[k] | ld[k+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
        begin
            if (ld[0])
                v_reg[0] <= s_tvalid;
            for (int k = 1; k < NS; k++)
            begin
                if (ld[k])
                    v_reg[k] <= v_reg[k-1];
            end
        end
    end

    assign s_tready = ld[0];
    assign m_tvalid = v_reg[NS-1];

    mi3_pkg::elem_t e [NE];
    for (genvar k = 0; k < NE; k++)
    begin : g_unpack
        assign e[k] = s_tdata[k*EW +: EW];
    end

    // stage 1: products
    logic signed [PW-1:0] pa_reg [NE];
    logic signed [PW-1:0] pb_reg [NE];
    mi3_pkg::elem_t       e1_reg [3];
    // stage 2: cofactors
    mi3_pkg::cof_t        c2_reg [NE];
    mi3_pkg::elem_t       e2_reg [3];
    // stage 3: partial products of the determinant terms
    logic signed [AW-1:0] lo_reg [3];
    logic signed [AW-1:0] hi_reg [3];
    mi3_pkg::cof_t        c3_reg [NE];
    // stage 4: terms
    logic signed [TW-1:0] t_reg  [3];
    mi3_pkg::cof_t        c4_reg [NE];
    // stage 5: determinant
    logic signed [DT-1:0] det_reg;
    mi3_pkg::cof_t        c5_reg [NE];
    // stage 6: magnitude and singular test
    logic [DA-1:0]        dabs_reg;
    logic                 dneg_reg;
    logic                 sing_reg;
    mi3_pkg::cof_t        c6_reg [NE];

    logic [DA-1:0] dabs_next;
    logic [DA-1:0] lim;

    assign dabs_next = det_reg[DT-1] ? DA'(-det_reg) : DA'(det_reg);
    assign lim       = DA'(thr_reg) << (2 * FRAC_BITS);

    always_ff @(posedge clk)
    begin
        if (ld[0])
        begin
            for (int k = 0; k < NE; k++)
            begin
                pa_reg[k] <= e[mi3_pkg::COF_SEL[k][0]] * e[mi3_pkg::COF_SEL[k][1]];
                pb_reg[k] <= e[mi3_pkg::COF_SEL[k][2]] * e[mi3_pkg::COF_SEL[k][3]];
            end
            for (int i = 0; i < 3; i++)
                e1_reg[i] <= e[mi3_pkg::DET_SEL[i]];
        end
        if (ld[1])
        begin
            for (int k = 0; k < NE; k++)
                c2_reg[k] <= CW'(pa_reg[k]) - CW'(pb_reg[k]);
            e2_reg <= e1_reg;
        end
        if (ld[2])
        begin
            for (int i = 0; i < 3; i++)
            begin
                lo_reg[i] <= AW'(e2_reg[i]) * AW'($signed({1'b0, c2_reg[i][EW-1:0]}));
                hi_reg[i] <= AW'(e2_reg[i]) * AW'($signed(c2_reg[i][CW-1:EW]));
            end
            c3_reg <= c2_reg;
        end
        if (ld[3])
        begin
            for (int i = 0; i < 3; i++)
                t_reg[i] <= (TW'(hi_reg[i]) <<< EW) + TW'(lo_reg[i]);
            c4_reg <= c3_reg;
        end
        if (ld[4])
        begin
            det_reg <= DT'(t_reg[0]) + DT'(t_reg[1]) + DT'(t_reg[2]);
            c5_reg  <= c4_reg;
        end
        if (ld[5])
        begin
            dabs_reg <= dabs_next;
            dneg_reg <= det_reg[DT-1];
            sing_reg <= (det_reg == '0) || (dabs_next < lim);
            c6_reg   <= c5_reg;
        end
    end

    logic [NE-1:0] zq;

    for (genvar k = 0; k < NE; k++)
    begin : g_div
        mi3_div #(
            .FRAC_BITS (FRAC_BITS)
        ) u_div (
            .clk    (clk),
            .ld     (ld[NS-1:TS]),
            .cof    (c6_reg[k]),
            .dabs   (dabs_reg),
            .dneg   (dneg_reg),
            .zero   (sing_reg),
            .q      (m_tdata[k*EW +: EW]),
            .zero_q (zq[k])
        );
    end

    assign m_tuser = zq[0];

    a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata == '0))
        else $error("singular beat with nonzero data");

    a_sing_agree: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (zq == '0 || zq == '1))
        else $error("divider lanes disagree on singular");

    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> v_reg[0])
        else $error("accepted beat not captured");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("output beat lost under stall");

endmodule

### verif/tb_matrix_inverse_3x3.sv
`timescale 1ns / 1ps

module tb_matrix_inverse_3x3;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 60;
    localparam int RAND_PER_PH = 120;

    typedef struct {
        logic [mi3_pkg::DATA_W-1:0] inv;
        logic                       sing;
    } inv_beat_t;

    class inverse_scoreboard;
        inv_beat_t    pending[$];
        logic [mi3_pkg::THR_W-1:0] thr;
        int           errors;
        int           checked;
        int           n_singular;
        int           n_saturated;

        function new();
            thr = mi3_pkg::THR_RESET;
            errors = 0;
            checked = 0;
            n_singular = 0;
            n_saturated = 0;
        endfunction

        function void set_threshold(logic [mi3_pkg::THR_W-1:0] v);
            thr = v;
        endfunction

        function inv_beat_t invert(logic [mi3_pkg::DATA_W-1:0] d);
            inv_beat_t          r;
            logic signed [127:0] e[mi3_pkg::N_ELEM];
            logic signed [127:0] cof[mi3_pkg::N_ELEM];
            logic signed [127:0] det;
            logic [127:0]        adet, lim, num, q, rem, mag;
            logic                neg;
            for (int k = 0; k < mi3_pkg::N_ELEM; k++)
                e[k] = mi3_pkg::elem_t'(d[k*mi3_pkg::ELEM_W +: mi3_pkg::ELEM_W]);
            for (int k = 0; k < mi3_pkg::N_ELEM; k++)
                cof[k] = e[mi3_pkg::COF_SEL[k][0]] * e[mi3_pkg::COF_SEL[k][1]]
                       - e[mi3_pkg::COF_SEL[k][2]] * e[mi3_pkg::COF_SEL[k][3]];
            det = e[mi3_pkg::DET_SEL[0]] * cof[0] + e[mi3_pkg::DET_SEL[1]] * cof[1]
                + e[mi3_pkg::DET_SEL[2]] * cof[2];
            adet = det[127] ? -det : det;
            lim = 128'(thr) << (2 * mi3_pkg::FRAC_BITS);
            r.inv = '0;
            r.sing = 1'b0;
            if (adet == 0 || adet < lim) begin
                r.sing = 1'b1;
                return r;
            end
            for (int k = 0; k < mi3_pkg::N_ELEM; k++) begin
                neg = cof[k][127] ^ det[127];
                num = (cof[k][127] ? -cof[k] : cof[k]);
                num = num << (2 * mi3_pkg::FRAC_BITS);
                q = num / adet;
                rem = num - q * adet;
                if ((rem << 1) >= adet)
                    q = q + 1;
                if (neg) begin
                    mag = (q > 128'h8000_0000) ? 128'h8000_0000 : q;
                    r.inv[k*mi3_pkg::ELEM_W +: mi3_pkg::ELEM_W] = 32'(-mag);
                end
                else begin
                    mag = (q > 128'h7FFF_FFFF) ? 128'h7FFF_FFFF : q;
                    r.inv[k*mi3_pkg::ELEM_W +: mi3_pkg::ELEM_W] = 32'(mag);
                end
            end
            return r;
        endfunction

        function void note_matrix(logic [mi3_pkg::DATA_W-1:0] d);
            pending.push_back(invert(d));
        endfunction

        function void check_inverse(logic [mi3_pkg::DATA_W-1:0] inv, logic sing);
            inv_beat_t                  exp_b;
            string                      fname;
            logic [mi3_pkg::ELEM_W-1:0] ev;
            logic [mi3_pkg::ELEM_W-1:0] av;
            if (pending.size() == 0) begin
                $error("unexpected output beat: tdata=%h tuser=%b", inv, sing);
                errors++;
                return;
            end
            exp_b = pending.pop_front();
            checked++;
            if (exp_b.sing)
                n_singular++;
            for (int k = 0; k < mi3_pkg::N_ELEM; k++) begin
                fname = $sformatf("inv_r%0d_c%0d", k % 3, k / 3);
                ev = exp_b.inv[k*mi3_pkg::ELEM_W +: mi3_pkg::ELEM_W];
                av = inv[k*mi3_pkg::ELEM_W +: mi3_pkg::ELEM_W];
                if (ev == 32'h7FFF_FFFF || ev == 32'h8000_0000)
                    n_saturated++;
                if (av !== ev) begin
                    $error("%s: expected %h, actual %h", fname, ev, av);
                    errors++;
                end
            end
            if (sing !== exp_b.sing) begin
                $error("singular: expected %b, actual %b", exp_b.sing, sing);
                errors++;
            end
        endfunction
    endclass

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_we;
    logic [mi3_pkg::THR_W-1:0]  cfg_wdata;
    logic                       s_tvalid;
    logic                       s_tready;
    logic [mi3_pkg::DATA_W-1:0] s_tdata;
    logic                       m_tvalid;
    logic                       m_tready;
    logic [mi3_pkg::DATA_W-1:0] m_tdata;
    logic                       m_tuser;

    inverse_scoreboard sb;
    int                tx_idle_pct;
    int                rx_idle_pct;
    int                cycles;
    int                n_sent;

    matrix_inverse_3x3 u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),     // m_r0_c0 .. m_r2_c2, column-major, 32b each
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),     // inv_r0_c0 .. inv_r2_c2, column-major, 32b each
        .m_tuser   (m_tuser)      // singular
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            m_tready <= 1'b0;
        end
        else begin
            if (m_tvalid && m_tready)
                sb.check_inverse(m_tdata, m_tuser);
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    function automatic logic [mi3_pkg::DATA_W-1:0] pack_diag(int unsigned a,
                                                             int unsigned b,
                                                             int unsigned c);
        logic [mi3_pkg::DATA_W-1:0] d;
        d = '0;
        d[0*mi3_pkg::ELEM_W +: mi3_pkg::ELEM_W] = a;
        d[4*mi3_pkg::ELEM_W +: mi3_pkg::ELEM_W] = b;
        d[8*mi3_pkg::ELEM_W +: mi3_pkg::ELEM_W] = c;
        return d;
    endfunction

    function automatic logic [mi3_pkg::ELEM_W-1:0] small_elem();
        return mi3_pkg::ELEM_W'($urandom_range(32'h0008_0000)) - 32'h0004_0000;
    endfunction

    function automatic logic [mi3_pkg::DATA_W-1:0] random_matrix();
        logic [mi3_pkg::DATA_W-1:0] d;
        int                         kind;
        int                         sel;
        kind = $urandom_range(9);
        for (int k = 0; k < mi3_pkg::N_ELEM; k++) begin
            case (kind)
                4, 5:    d[k*mi3_pkg::ELEM_W +: mi3_pkg::ELEM_W] = $urandom;
                9: begin
                    sel = $urandom_range(3);
                    d[k*mi3_pkg::ELEM_W +: mi3_pkg::ELEM_W] =
                        (sel == 0) ? 32'h8000_0000 :
                        (sel == 1) ? 32'h7FFF_FFFF :
                        (sel == 2) ? 32'h0 : $urandom;
                end
                default: d[k*mi3_pkg::ELEM_W +: mi3_pkg::ELEM_W] = small_elem();
            endcase
        end
        if (kind == 6) begin
            // third column = first column plus a tiny offset: near singular
            for (int k = 0; k < 3; k++)
                d[(6+k)*mi3_pkg::ELEM_W +: mi3_pkg::ELEM_W] =
                    d[k*mi3_pkg::ELEM_W +: mi3_pkg::ELEM_W]
                    + mi3_pkg::ELEM_W'($urandom_range(4)) - 2;
        end
        else if (kind == 7) begin
            for (int k = 0; k < 3; k++)
                d[(3+k)*mi3_pkg::ELEM_W +: mi3_pkg::ELEM_W] =
                    d[k*mi3_pkg::ELEM_W +: mi3_pkg::ELEM_W];
        end
        else if (kind == 8) begin
            d = pack_diag($urandom >> $urandom_range(31), $urandom >> $urandom_range(31),
                          $urandom >> $urandom_range(31));
        end
        return d;
    endfunction

    task automatic send_matrix(logic [mi3_pkg::DATA_W-1:0] d);
        if ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < tx_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata <= d;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_matrix(d);
        n_sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_threshold(logic [mi3_pkg::THR_W-1:0] v);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_threshold(v);
    endtask

    task automatic set_idling(int mode);
        case (mode % 3)
            0: begin tx_idle_pct = 8;  rx_idle_pct = 79; end
            1: begin tx_idle_pct = 79; rx_idle_pct = 8;  end
            default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
        endcase
    endtask

    logic [mi3_pkg::THR_W-1:0]  thr_plan[5];
    logic [mi3_pkg::DATA_W-1:0] d;

    initial
    begin
        sb = new();
        cycles = 0;
        n_sent = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        set_idling(0);
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, reset threshold
        send_matrix('0);
        send_matrix(pack_diag(32'h0001_0000, 32'h0001_0000, 32'h0001_0000));
        send_matrix(pack_diag(32'hFFFF_0000, 32'hFFFF_0000, 32'hFFFF_0000));
        send_matrix(pack_diag(32'h0002_0000, 32'h0004_0000, 32'h0008_0000));
        send_matrix(pack_diag(32'h0000_0100, 32'h0000_0100, 32'h0000_0100));
        send_matrix(pack_diag(32'h0000_0001, 32'h0000_0001, 32'h0000_0001));
        send_matrix(pack_diag(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        send_matrix(pack_diag(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        send_matrix(pack_diag(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001));
        send_matrix(pack_diag(32'h0003_0000, 32'h0003_0000, 32'h0003_0000));
        send_matrix('1);
        send_matrix({mi3_pkg::N_ELEM{32'h7FFF_FFFF}});
        send_matrix({mi3_pkg::N_ELEM{32'h8000_0000}});
        d = '0;
        for (int k = 0; k < mi3_pkg::N_ELEM; k++)
            d[k*mi3_pkg::ELEM_W +: mi3_pkg::ELEM_W] =
                (k % 2) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        send_matrix(d);
        for (int k = 0; k < mi3_pkg::N_ELEM; k++)
            d[k*mi3_pkg::ELEM_W +: mi3_pkg::ELEM_W] = 32'((k + 1) << 16);
        send_matrix(d);
        d[8*mi3_pkg::ELEM_W +: mi3_pkg::ELEM_W] = 32'h000A_0000;
        send_matrix(d);
        for (int k = 0; k < 6; k++)
            send_matrix(random_matrix());
        drain();

        thr_plan[0] = '0;
        thr_plan[1] = '1;
        thr_plan[2] = mi3_pkg::THR_W'($urandom_range(1000));
        thr_plan[3] = mi3_pkg::THR_W'(1);
        thr_plan[4] = mi3_pkg::THR_W'($urandom);
        for (int ph = 0; ph < 5; ph++) begin
            write_threshold(thr_plan[ph]);
            set_idling(ph);
            for (int i = 0; i < RAND_PER_PH; i++)
                send_matrix(random_matrix());
            drain();
        end

        $display("Sent %0d matrices over 6 phases, threshold 0 to max; %0d checked,",
                 n_sent, sb.checked);
        $display("%0d singular, %0d saturated elements.", sb.n_singular, sb.n_saturated);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
